// ===== design/cfa_pkg.sv =====
// Shared types, constants and helpers for the colour fade block.
`timescale 1ns / 1ps

package cfa_pkg;

   localparam int TIME_BITS    = 24;
   localparam int CHANNEL_BITS = 8;
   localparam int COLOR_BITS   = 32;
   localparam int NUM_CHANNELS = 4;
   localparam int CHAN_IDX_BITS = $clog2(NUM_CHANNELS);
   localparam int STEP_BITS    = $clog2(CHANNEL_BITS);
   localparam int ADDR_BITS    = 4;

   // request modes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_PLAY  = 2'd1;
   localparam logic [1:0] MODE_DELAY = 2'd2;

   // register indexes
   localparam logic [1:0] REG_START_COLOR = 2'd0;
   localparam logic [1:0] REG_END_COLOR   = 2'd1;
   localparam logic [1:0] REG_DURATION    = 2'd2;
   localparam logic [1:0] REG_LOOP_ENABLE = 2'd3;

   localparam logic [COLOR_BITS-1:0] START_COLOR_RESET = '0;
   localparam logic [COLOR_BITS-1:0] END_COLOR_RESET   = '1;
   localparam logic [TIME_BITS-1:0]  DURATION_RESET    = '0;
   localparam logic                  LOOP_ENABLE_RESET = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] amount;
   } req_type;

   typedef struct packed {
      logic       color_write;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       playing;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic                     load;
      logic                     eval;
      logic                     mul;
      logic                     div;
      logic                     fin;
      logic [CHAN_IDX_BITS-1:0] chan;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_blend;
   } status_type;

   // channel 0 is red in the top byte, channel 3 alpha in the bottom byte
   function automatic logic [CHANNEL_BITS-1:0] chan_of(
      input logic [COLOR_BITS-1:0]    word_in,
      input logic [CHAN_IDX_BITS-1:0] k
   );
      logic [CHANNEL_BITS-1:0] r;
      case (k)
         2'd0:    r = word_in[3*CHANNEL_BITS +: CHANNEL_BITS];
         2'd1:    r = word_in[2*CHANNEL_BITS +: CHANNEL_BITS];
         2'd2:    r = word_in[1*CHANNEL_BITS +: CHANNEL_BITS];
         default: r = word_in[0 +: CHANNEL_BITS];
      endcase
      return r;
   endfunction

endpackage

// ===== design/cfa_ctrl.sv =====
// Sequencer that steps one request through evaluate, per-channel multiply, divide and finish, and publish.
`timescale 1ns / 1ps

module cfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   slot_free,
   input  cfa_pkg::status_type    status,
   output logic                   req_ready,
   output logic                   rsp_load,
   output cfa_pkg::cmd_type       cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EVAL = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [cfa_pkg::CHAN_IDX_BITS-1:0] chan_ff, chan_in;
   logic [cfa_pkg::STEP_BITS-1:0]     step_ff, step_in;

   localparam logic [cfa_pkg::STEP_BITS-1:0] LAST_STEP =
      cfa_pkg::STEP_BITS'(cfa_pkg::CHANNEL_BITS - 1);
   localparam logic [cfa_pkg::CHAN_IDX_BITS-1:0] LAST_CHAN =
      cfa_pkg::CHAN_IDX_BITS'(cfa_pkg::NUM_CHANNELS - 1);

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      cmd       = '0;
      cmd.chan  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            chan_in  = '0;
            state_in = status.need_blend ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            chan_in = chan_ff + 1'b1;
            state_in = (chan_ff == LAST_CHAN) ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== design/cfa_dpath.sv =====
// Fade state, per-channel multiply and shift-subtract divide, colour result registers.
`timescale 1ns / 1ps

module cfa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  cfa_pkg::cmd_type                    cmd,
   input  cfa_pkg::req_type                    req_data,
   input  logic [cfa_pkg::COLOR_BITS-1:0]      start_color,
   input  logic [cfa_pkg::COLOR_BITS-1:0]      end_color,
   input  logic [cfa_pkg::TIME_BITS-1:0]       duration,
   input  logic                                loop_enable,
   output cfa_pkg::status_type                 status,
   output cfa_pkg::rsp_type                    result
);

   localparam int TB = cfa_pkg::TIME_BITS;
   localparam int CB = cfa_pkg::CHANNEL_BITS;

   logic [1:0]    mode_ff;
   logic [TB-1:0] amount_ff;
   logic [TB-1:0] elapsed_ff;
   logic [TB-1:0] delay_ff;
   logic          active_ff;
   logic          write_ff;
   logic [CB-1:0] color_ff [cfa_pkg::NUM_CHANNELS];
   logic          neg_ff;
   logic [CB-1:0] base_ff;
   logic [TB-1:0] rem_ff;
   logic [CB-1:0] quo_ff;

   // evaluate step
   logic          is_tick;
   logic [TB:0]   sum;
   logic [TB-1:0] sat_sum;

   assign is_tick = (mode_ff == cfa_pkg::MODE_TICK);
   assign sum     = {1'b0, elapsed_ff} + {1'b0, amount_ff};
   assign sat_sum = sum[TB] ? '1 : sum[TB-1:0];
   assign status.need_blend = is_tick && active_ff && (delay_ff == '0) && (sat_sum < duration);

   // multiply step
   logic [CB-1:0]    s_chan, e_chan, mag;
   logic             neg;
   logic [CB+TB-1:0] prod;

   assign s_chan = cfa_pkg::chan_of(start_color, cmd.chan);
   assign e_chan = cfa_pkg::chan_of(end_color, cmd.chan);
   assign neg    = (e_chan < s_chan);
   assign mag    = neg ? (s_chan - e_chan) : (e_chan - s_chan);
   assign prod   = {{TB{1'b0}}, mag} * {{CB{1'b0}}, elapsed_ff};

   // divide step: the quotient is below 2**CB, so only CB steps are needed
   logic [TB:0] trial, trial_sub;
   logic        ge;

   assign trial     = {rem_ff, quo_ff[CB-1]};
   assign ge        = (trial >= {1'b0, duration});
   assign trial_sub = trial - {1'b0, duration};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_data.mode;
         amount_ff <= req_data.amount;
      end
      if (cmd.mul) begin
         rem_ff  <= prod[CB+TB-1:CB];
         quo_ff  <= prod[CB-1:0];
         base_ff <= s_chan;
         neg_ff  <= neg;
      end else if (cmd.div) begin
         rem_ff <= ge ? trial_sub[TB-1:0] : trial[TB-1:0];
         quo_ff <= {quo_ff[CB-2:0], ge};
      end
      if (cmd.eval) begin
         if (status.need_blend) begin
            write_ff <= 1'b1;
            for (int k = 0; k < cfa_pkg::NUM_CHANNELS; k++) begin
               color_ff[k] <= '0;
            end
         end else if (is_tick && active_ff && (delay_ff == '0) && !loop_enable) begin
            write_ff <= 1'b1;
            for (int k = 0; k < cfa_pkg::NUM_CHANNELS; k++) begin
               color_ff[k] <= cfa_pkg::chan_of(end_color, cfa_pkg::CHAN_IDX_BITS'(k));
            end
         end else begin
            write_ff <= 1'b0;
            for (int k = 0; k < cfa_pkg::NUM_CHANNELS; k++) begin
               color_ff[k] <= '0;
            end
         end
      end else if (cmd.fin) begin
         color_ff[cmd.chan] <= neg_ff ? (base_ff - quo_ff) : (base_ff + quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         delay_ff   <= '0;
         active_ff  <= 1'b0;
      end else if (cmd.eval) begin
         case (mode_ff)
            cfa_pkg::MODE_TICK: begin
               if (active_ff) begin
                  if (delay_ff != '0) begin
                     delay_ff <= (amount_ff >= delay_ff) ? '0 : (delay_ff - amount_ff);
                  end else if (sat_sum < duration) begin
                     elapsed_ff <= sat_sum;
                  end else if (loop_enable) begin
                     elapsed_ff <= '0;
                  end else begin
                     elapsed_ff <= sat_sum;
                     active_ff  <= 1'b0;
                  end
               end
            end
            cfa_pkg::MODE_PLAY: begin
               elapsed_ff <= '0;
               active_ff  <= 1'b1;
            end
            cfa_pkg::MODE_DELAY: begin
               delay_ff <= amount_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result             = '0;
      result.color_write = write_ff;
      result.red         = 8'(color_ff[0]);
      result.green       = 8'(color_ff[1]);
      result.blue        = 8'(color_ff[2]);
      result.alpha       = 8'(color_ff[3]);
      result.playing     = active_ff;
   end

endmodule

// ===== design/color_fade_animator.sv =====
// Top level of the RGBA colour fade block: register port, sequencer, datapath, output register.
`timescale 1ns / 1ps

// Usage
//   Requests arrive on req_valid/req_ready/req_data (mode, amount). Mode tick advances
//   the fade (or counts a pending delay down), play restarts time and activates the
//   fade, set delay loads the delay. Every request yields exactly one response on
//   rsp_valid/rsp_ready/rsp_data: color_write flags a driven colour, red..alpha hold
//   it (zero when none is driven), playing gives the active flag after the request.
//   Registers start_color, end_color, duration and loop_enable sit at byte addresses
//   0, 4, 8 and 12 of the csr_ port; write them only while the block is idle.
// Sequencing
//   One request at a time. A tick that interpolates runs one evaluate step, then per
//   channel one multiply, eight divide and one finish step on a shared multiplier and
//   shift-subtract divider, then loads the output register once it is free. Other
//   requests go from evaluate straight to that load. The next request is accepted in
//   the cycle after the load.
// Reset
//   Synchronous reset stops the fade, clears elapsed time and delay, and returns the
//   registers to their reset values; no response is pending afterwards.
// Stalls
//   A finished response waits in the output register; the next request is accepted
//   and worked on meanwhile, holding its result until the output register frees up.
module color_fade_animator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cfa_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cfa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cfa_pkg::ADDR_BITS-1:0]     csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   // configuration registers
   logic [cfa_pkg::COLOR_BITS-1:0] start_color_ff;
   logic [cfa_pkg::COLOR_BITS-1:0] end_color_ff;
   logic [cfa_pkg::TIME_BITS-1:0]  duration_ff;
   logic                           loop_enable_ff;
   logic                           csr_write;
   logic [1:0]                     csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_color_ff <= cfa_pkg::START_COLOR_RESET;
         end_color_ff   <= cfa_pkg::END_COLOR_RESET;
         duration_ff    <= cfa_pkg::DURATION_RESET;
         loop_enable_ff <= cfa_pkg::LOOP_ENABLE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            cfa_pkg::REG_START_COLOR: start_color_ff <= csr_pwdata;
            cfa_pkg::REG_END_COLOR:   end_color_ff   <= csr_pwdata;
            cfa_pkg::REG_DURATION:    duration_ff    <= csr_pwdata[cfa_pkg::TIME_BITS-1:0];
            cfa_pkg::REG_LOOP_ENABLE: loop_enable_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // read back: zero-extend the narrow registers
   always_comb begin
      case (csr_index)
         cfa_pkg::REG_START_COLOR: csr_prdata = start_color_ff;
         cfa_pkg::REG_END_COLOR:   csr_prdata = end_color_ff;
         cfa_pkg::REG_DURATION:    csr_prdata = 32'(duration_ff);
         cfa_pkg::REG_LOOP_ENABLE: csr_prdata = 32'(loop_enable_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // sequencer and datapath
   cfa_pkg::cmd_type    cmd;
   cfa_pkg::status_type status;
   cfa_pkg::rsp_type    result;
   logic                rsp_load;
   logic                slot_free;

   // output register state
   logic             rsp_valid_ff;
   cfa_pkg::rsp_type rsp_data_ff;

   // the output register frees up when empty or when its response is taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .slot_free (slot_free),
      .status    (status),
      .req_ready (req_ready),
      .rsp_load  (rsp_load),
      .cmd       (cmd)
   );

   cfa_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .start_color (start_color_ff),
      .end_color   (end_color_ff),
      .duration    (duration_ff),
      .loop_enable (loop_enable_ff),
      .status      (status),
      .result      (result)
   );

   // output register: hold the response until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/color_fade_animator_tb.sv =====
// Self-checking testbench for the colour fade block: directed table, then random phases.
`timescale 1ns / 1ps

module color_fade_animator_tb;

   // mode 3 is not decoded by the block; the package leaves it unnamed
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 12;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 67;
   // drain time covers a blending tick, plus a full stall and a sender gap
   localparam int DRAIN_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 10;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   // one line of the directed table: a register write or a request,
   // with an expected response typed in where it is obvious
   typedef struct {
      row_kind_type     kind;
      logic [1:0]       code;
      logic [31:0]      value;
      bit               typed;
      cfa_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cfa_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b1;
   cfa_pkg::rsp_type rsp_data;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [cfa_pkg::ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // expectation travelling with the request on the bus
   bit               pend_typed = 1'b0;
   cfa_pkg::rsp_type pend_want = '0;

   // predictor copy of the registers and of the fade state
   logic [31:0]      reg_start;
   logic [31:0]      reg_end;
   logic [23:0]      reg_duration;
   logic             reg_loop;
   logic [23:0]      fade_elapsed;
   logic [23:0]      fade_delay;
   logic             fade_active;

   cfa_pkg::rsp_type expected_colors[$];
   stim_row_type     stim_rows[$];

   int               requests_sent = 0;
   int               responses_seen = 0;
   int               mismatches = 0;
   int               quiet_cycles = 0;
   bit               idle_on = 1'b0;
   int               drv_duration = 0;

   color_fade_animator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   function automatic void fade_reset();
      reg_start    = cfa_pkg::START_COLOR_RESET;
      reg_end      = cfa_pkg::END_COLOR_RESET;
      reg_duration = cfa_pkg::DURATION_RESET;
      reg_loop     = cfa_pkg::LOOP_ENABLE_RESET;
      fade_elapsed = '0;
      fade_delay   = '0;
      fade_active  = 1'b0;
   endfunction

   function automatic void fade_reg_write(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
         cfa_pkg::REG_START_COLOR: reg_start    = val;
         cfa_pkg::REG_END_COLOR:   reg_end      = val;
         cfa_pkg::REG_DURATION:    reg_duration = val[23:0];
         cfa_pkg::REG_LOOP_ENABLE: reg_loop     = val[0];
         default: ;
      endcase
   endfunction

   // Advance the fade state by one request and return the response it yields.
   function automatic cfa_pkg::rsp_type fade_step(input cfa_pkg::req_type item);
      logic [24:0]      sum;
      logic [7:0]       ch [4];
      logic [7:0]       s_ch;
      logic [7:0]       e_ch;
      longint           diff;
      longint           delta;
      logic             write;
      cfa_pkg::rsp_type res;
      for (int k = 0; k < 4; k++) ch[k] = '0;
      write = 1'b0;
      case (item.mode)
         cfa_pkg::MODE_TICK: begin
            if (fade_active) begin
               if (fade_delay != 0) begin
                  // a pending delay swallows the whole tick
                  fade_delay = (item.amount >= fade_delay) ? 24'd0 : fade_delay - item.amount;
               end else begin
                  sum = {1'b0, fade_elapsed} + {1'b0, item.amount};
                  fade_elapsed = sum[24] ? 24'hFFFFFF : sum[23:0];
                  if (fade_elapsed < reg_duration) begin
                     for (int k = 0; k < 4; k++) begin
                        s_ch  = reg_start[31-8*k -: 8];
                        e_ch  = reg_end[31-8*k -: 8];
                        diff  = longint'(e_ch) - longint'(s_ch);
                        // signed division truncates toward zero, as the block must
                        delta = (diff * longint'(fade_elapsed)) / longint'(reg_duration);
                        ch[k] = 8'(longint'(s_ch) + delta);
                     end
                     write = 1'b1;
                  end else if (reg_loop) begin
                     fade_elapsed = '0;
                  end else begin
                     for (int k = 0; k < 4; k++) ch[k] = reg_end[31-8*k -: 8];
                     write = 1'b1;
                     fade_active = 1'b0;
                  end
               end
            end
         end
         cfa_pkg::MODE_PLAY: begin
            fade_elapsed = '0;
            fade_active  = 1'b1;
         end
         cfa_pkg::MODE_DELAY: fade_delay = item.amount;
         default: ;
      endcase
      res.color_write = write;
      res.red         = ch[0];
      res.green       = ch[1];
      res.blue        = ch[2];
      res.alpha       = ch[3];
      res.playing     = fade_active;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Monitor: predict on every accepted request, check every response
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      cfa_pkg::rsp_type want;
      if (reset) begin
         fade_reset();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            fade_reg_write(csr_paddr[3:2], csr_pwdata);
         if (req_valid && req_ready) begin
            want = fade_step(req_data);
            // a typed-in row overrides the predictor, which still advances
            if (pend_typed) want = pend_want;
            expected_colors = {expected_colors, want};
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_colors.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response: cw=%0d rgba=%02h%02h%02h%02h playing=%0d",
                           rsp_data.color_write, rsp_data.red, rsp_data.green,
                           rsp_data.blue, rsp_data.alpha, rsp_data.playing);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.color_write !== want.color_write || rsp_data.red !== want.red ||
                   rsp_data.green !== want.green || rsp_data.blue !== want.blue ||
                   rsp_data.alpha !== want.alpha || rsp_data.playing !== want.playing) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: expected cw=%0d rgba=%02h%02h%02h%02h playing=%0d, %s",
                              want.color_write, want.red, want.green, want.blue, want.alpha,
                              want.playing, $sformatf("got cw=%0d rgba=%02h%02h%02h%02h playing=%0d",
                              rsp_data.color_write, rsp_data.red, rsp_data.green,
                              rsp_data.blue, rsp_data.alpha, rsp_data.playing));
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which nothing is accepted and the register port is idle.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Response side: stall in random bursts while idling is on, otherwise keep ready high.
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------

   // Present one request and hold it until accepted. Valid stays high afterwards;
   // the next call either reloads the payload or drops valid for a gap.
   task automatic send_req(input logic [1:0] mode, input logic [23:0] amount,
                           input bit typed, input cfa_pkg::rsp_type want);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data.mode   <= mode;
      req_data.amount <= amount;
      pend_typed      <= typed;
      pend_want       <= want;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Drop valid and hold until every request has had its response.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (responses_seen != requests_sent) @(posedge clock);
   endtask

   // Setup phase, access phase, then the port is released.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= cfa_pkg::ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == cfa_pkg::REG_DURATION) drv_duration = int'(val[23:0]);
   endtask

   function automatic void add_req(input logic [1:0] mode, input logic [23:0] amount,
                                   input bit typed, input cfa_pkg::rsp_type want);
      stim_row_type row;
      row = '{ROW_REQ, mode, {8'd0, amount}, typed, want};
      stim_rows = {stim_rows, row};
   endfunction

   function automatic void add_csr(input logic [1:0] idx, input logic [31:0] val);
      stim_row_type row;
      row = '{ROW_CSR, idx, val, 1'b0, '0};
      stim_rows = {stim_rows, row};
   endfunction

   function automatic logic [31:0] pick_color();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------

   initial begin
      cfa_pkg::rsp_type idle_stop;
      cfa_pkg::rsp_type idle_play;
      logic [1:0]       mode;
      logic [31:0]      amount;
      logic [23:0]      dur;
      int               sel;
      int               counted;

      idle_stop = cfa_pkg::rsp_type'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
      idle_play = cfa_pkg::rsp_type'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};

      // Reset state: zero duration, looping, end colour all ones.
      add_req(cfa_pkg::MODE_TICK, 24'h000000, 1'b1, idle_stop);   // tick while stopped
      add_req(cfa_pkg::MODE_TICK, 24'hFFFFFF, 1'b1, idle_stop);
      add_req(MODE_UNUSED,        24'hFFFFFF, 1'b1, idle_stop);   // unused mode is ignored
      add_req(cfa_pkg::MODE_PLAY, 24'h000000, 1'b1, idle_play);
      add_req(cfa_pkg::MODE_TICK, 24'h000000, 1'b1, idle_play);   // zero duration, loop restarts
      add_csr(cfa_pkg::REG_LOOP_ENABLE, 32'd0);
      add_req(cfa_pkg::MODE_TICK, 24'h000005, 1'b1,
              cfa_pkg::rsp_type'{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});  // ends on end colour
      // rising red, falling green, small blue step, flat alpha
      add_csr(cfa_pkg::REG_START_COLOR, 32'h00FF_8040);
      add_csr(cfa_pkg::REG_END_COLOR,   32'hFF00_C040);
      add_csr(cfa_pkg::REG_DURATION,    32'd100);
      add_req(cfa_pkg::MODE_DELAY, 24'd30, 1'b1, idle_stop);      // delay loads while stopped
      add_req(cfa_pkg::MODE_PLAY,  24'd0,  1'b1, idle_play);      // play keeps the delay
      add_req(cfa_pkg::MODE_TICK,  24'd10, 1'b1, idle_play);      // delay counts down
      add_req(cfa_pkg::MODE_TICK,  24'd25, 1'b1, idle_play);      // delay saturates at zero
      add_req(cfa_pkg::MODE_TICK,  24'd1,  1'b0, '0);
      add_req(cfa_pkg::MODE_TICK,  24'd49, 1'b0, '0);
      add_req(cfa_pkg::MODE_TICK,  24'd49, 1'b0, '0);
      add_req(cfa_pkg::MODE_TICK,  24'd1,  1'b1,
              cfa_pkg::rsp_type'{1'b1, 8'hFF, 8'h00, 8'hC0, 8'h40, 1'b0});
      // longest duration, full-scale falling fade
      add_csr(cfa_pkg::REG_LOOP_ENABLE, 32'd1);
      add_csr(cfa_pkg::REG_DURATION,    32'h00FF_FFFF);
      add_csr(cfa_pkg::REG_START_COLOR, 32'hFFFF_FFFF);
      add_csr(cfa_pkg::REG_END_COLOR,   32'h0000_0000);
      add_req(cfa_pkg::MODE_PLAY,  24'hFFFFFF, 1'b1, idle_play);
      add_req(cfa_pkg::MODE_TICK,  24'hFFFFFE, 1'b0, '0);
      add_req(cfa_pkg::MODE_TICK,  24'hFFFFFF, 1'b1, idle_play);  // elapsed saturates, loops
      add_req(cfa_pkg::MODE_DELAY, 24'hFFFFFF, 1'b1, idle_play);  // delay while playing
      add_req(cfa_pkg::MODE_TICK,  24'hFFFFFF, 1'b1, idle_play);
      add_req(cfa_pkg::MODE_TICK,  24'h000000, 1'b0, '0);         // blend at time zero
      add_req(MODE_UNUSED,         24'h000000, 1'b1, idle_play);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(stim_rows[i].code, stim_rows[i].value);
         end else begin
            send_req(stim_rows[i].code, stim_rows[i].value[23:0],
                     stim_rows[i].typed, stim_rows[i].want);
         end
      end

      // Random phases: fresh registers each phase, then mostly well-paced ticks
      // sized to the duration, mixed with plays, delays and raw noise.
      for (int phase = 0; phase < PHASES; phase++) begin
         idle_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
         wait_idle();
         case ($urandom_range(0, 9))
            0:       dur = 24'd0;
            1:       dur = 24'd1;
            2:       dur = 24'hFFFFFF;
            3:       dur = 24'($urandom_range(2, 20));
            default: dur = 24'($urandom_range(2, 400));
         endcase
         csr_write(cfa_pkg::REG_START_COLOR, pick_color());
         csr_write(cfa_pkg::REG_END_COLOR, pick_color());
         csr_write(cfa_pkg::REG_DURATION, {8'd0, dur});
         csr_write(cfa_pkg::REG_LOOP_ENABLE, {31'd0, 1'($urandom_range(0, 1))});
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
               mode = cfa_pkg::MODE_PLAY;
               amount = $urandom;
            end else if (sel < 14) begin
               mode = cfa_pkg::MODE_DELAY;
               amount = $urandom_range(0, 1) ? $urandom_range(0, drv_duration / 4 + 3) : $urandom;
            end else if (sel < 17) begin
               mode = MODE_UNUSED;
               amount = $urandom;
            end else if (sel < 22) begin
               mode = cfa_pkg::MODE_TICK;
               amount = $urandom;
            end else begin
               mode = cfa_pkg::MODE_TICK;
               amount = $urandom_range(0, drv_duration / 6 + 1);
            end
            send_req(mode, amount[23:0], 1'b0, '0);
            if (mode != MODE_UNUSED) counted++;
         end
      end

      idle_on = 1'b0;
      wait_idle();
      // let any stray response show itself
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_colors.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
